[rtl/ffrsa_pkg.sv]
`default_nettype none

package ffrsa_pkg;

   // Field widths of the request and response items
   localparam int FUNC_W   = 2;
   localparam int IDX_IN_W = 8;
   localparam int AMT_W    = 9;
   localparam int CNT_IN_W = 16;
   localparam int STATUS_W = 2;
   localparam int BASE_W   = 8;
   localparam int LEN_W    = 9;

   // Operation selector
   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC = 2'd0,
      FUNC_SET   = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_NO_RUN = 2'd1,
      ST_RANGE  = 2'd2,
      ST_AMOUNT = 2'd3
   } status_type;

   // Controller states
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_ALLOC_WR,
      S_READ_CAP,
      S_SET_PROP,
      S_DONE
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       clear;
      logic       load;
      logic       len_rd;
      logic       scan;
      logic       alloc_wr;
      logic       len_cap;
      logic       prop;
      logic       len_clr;
      logic       fail;
      status_type fail_code;
      logic       publish;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic     clr_last;
      func_type func;
      logic     amount_zero;
      logic     idx_ok;
      logic     hit;
      logic     scan_fail;
      logic     prop_done;
      logic     value_zero;
      logic     out_free;
   } stat_type;

endpackage

`default_nettype wire

[rtl/ffrsa_if.sv]
`default_nettype none

// Request channel
interface ffrsa_req_if;
   import ffrsa_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [IDX_IN_W-1:0] slot_index;
   logic [AMT_W-1:0]    run_amount;
   logic [CNT_IN_W-1:0] count_value;

   modport source (output valid, output func, output slot_index, output run_amount,
                   output count_value, input ready);
   modport sink (input valid, input func, input slot_index, input run_amount,
                 input count_value, output ready);
endinterface

// Response channel
interface ffrsa_rsp_if;
   import ffrsa_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BASE_W-1:0]   base_index;
   logic [LEN_W-1:0]    length_read;

   modport source (output valid, output status, output base_index, output length_read,
                   input ready);
   modport sink (input valid, input status, input base_index, input length_read,
                 output ready);
endinterface

`default_nettype wire

[rtl/ffrsa_ctrl.sv]
`default_nettype none

module ffrsa_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire ffrsa_pkg::stat_type stat,
   output ffrsa_pkg::cmd_type       cmd
);
   import ffrsa_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            unique case (stat.func)
               FUNC_ALLOC: state_in = stat.amount_zero ? S_DONE : S_SCAN;
               FUNC_SET:   state_in = stat.idx_ok ? S_SET_PROP : S_DONE;
               FUNC_READ:  state_in = stat.idx_ok ? S_READ_CAP : S_DONE;
               FUNC_NONE:  state_in = S_DONE;
               default:    state_in = S_DONE;
            endcase
         end
         S_SCAN: begin
            if (stat.hit) begin
               state_in = S_ALLOC_WR;
            end else if (stat.scan_fail) begin
               state_in = S_DONE;
            end
         end
         S_ALLOC_WR: state_in = S_DONE;
         S_READ_CAP: state_in = S_DONE;
         S_SET_PROP: begin
            if (stat.prop_done) state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: cmd.clear = 1'b1;
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_DECODE: begin
            cmd.len_rd = 1'b1;
            unique case (stat.func)
               FUNC_ALLOC: begin
                  if (stat.amount_zero) begin
                     cmd.fail      = 1'b1;
                     cmd.fail_code = ST_AMOUNT;
                  end
               end
               FUNC_SET, FUNC_READ: begin
                  if (!stat.idx_ok) begin
                     cmd.fail      = 1'b1;
                     cmd.fail_code = ST_RANGE;
                  end
               end
               FUNC_NONE: ;
               default: ;
            endcase
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_fail && !stat.hit) begin
               cmd.fail      = 1'b1;
               cmd.fail_code = ST_NO_RUN;
            end
         end
         S_ALLOC_WR: cmd.alloc_wr = 1'b1;
         S_READ_CAP: cmd.len_cap = 1'b1;
         S_SET_PROP: begin
            cmd.prop    = 1'b1;
            cmd.len_clr = stat.prop_done && stat.value_zero;
         end
         S_DONE: cmd.publish = stat.out_free;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

[rtl/ffrsa_dp.sv]
`default_nettype none

module ffrsa_dp #(
   parameter int SLOTS      = 256,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [ffrsa_pkg::FUNC_W-1:0]       req_func,
   input  wire logic [ffrsa_pkg::IDX_IN_W-1:0]     req_slot_index,
   input  wire logic [ffrsa_pkg::AMT_W-1:0]        req_run_amount,
   input  wire logic [ffrsa_pkg::CNT_IN_W-1:0]     req_count_value,
   input  wire ffrsa_pkg::cmd_type                 cmd,
   output ffrsa_pkg::stat_type                     stat,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [ffrsa_pkg::STATUS_W-1:0]          rsp_status,
   output logic [ffrsa_pkg::BASE_W-1:0]            rsp_base_index,
   output logic [ffrsa_pkg::LEN_W-1:0]             rsp_length_read
);
   import ffrsa_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PW    = IDX_W + 1;
   localparam int HW    = ((IDX_W > AMT_W) ? IDX_W : AMT_W) + 1;
   localparam int KW    = LEN_W + 1;

   // Heap storage
   logic [COUNT_BITS-1:0] ref_mem [SLOTS];
   logic [LEN_W-1:0]      len_mem [SLOTS];

   // Latched item
   func_type              func_ff;
   logic [IDX_IN_W-1:0]   idx_ff;
   logic [AMT_W-1:0]      amount_ff;
   logic [COUNT_BITS-1:0] value_ff;
   logic [31:0]           value_wide;

   // Counters and scan tracking
   logic [PW-1:0]         ptr_ff, ptr_in;
   logic [IDX_W-1:0]      tag_ff;
   logic                  tvalid_ff, tvalid_in;
   logic [AMT_W-1:0]      run_ff, run_in;
   logic [KW-1:0]         k_ff, k_in;
   logic [IDX_W-1:0]      head_ff;

   // Memory read data
   logic [COUNT_BITS-1:0] ref_rd_ff;
   logic [LEN_W-1:0]      len_rd_ff;

   // Result and output registers
   status_type            res_status_ff;
   logic [BASE_W-1:0]     res_base_ff;
   logic [LEN_W-1:0]      res_len_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [BASE_W-1:0]     rsp_base_ff;
   logic [LEN_W-1:0]      rsp_len_ff;

   logic [HW-1:0]         idx_hw;
   logic [IDX_W-1:0]      idx_addr;
   logic                  scan_issue;
   logic                  slot_free;
   logic [AMT_W:0]        run_inc;
   logic                  hit;
   logic [HW-1:0]         head_full;
   logic [HW-1:0]         prop_sum;
   logic                  prop_go;

   logic                  ref_we;
   logic [IDX_W-1:0]      ref_waddr;
   logic [COUNT_BITS-1:0] ref_wdata;
   logic                  len_we;
   logic [IDX_W-1:0]      len_waddr;
   logic [LEN_W-1:0]      len_wdata;

   assign value_wide = {16'b0, req_count_value};
   assign idx_hw     = HW'(idx_ff);
   assign idx_addr   = idx_hw[IDX_W-1:0];

   // Item latch
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff   <= func_type'(req_func);
         idx_ff    <= req_slot_index;
         amount_ff <= req_run_amount;
         value_ff  <= value_wide[COUNT_BITS-1:0];
      end
   end

   // First-fit scan: one count read per cycle, its data checked in the cycle after
   assign scan_issue = cmd.scan && (ptr_ff < PW'(SLOTS));
   assign slot_free  = (ref_rd_ff == '0);
   assign run_inc    = {1'b0, run_ff} + (AMT_W+1)'(1);
   assign hit        = tvalid_ff && slot_free && (run_inc == {1'b0, amount_ff});
   assign head_full  = HW'(tag_ff) + HW'(1) - HW'(amount_ff);

   // Count propagation over the run
   assign prop_sum = idx_hw + HW'(k_ff);
   assign prop_go  = ((k_ff == '0) || (k_ff < KW'(len_rd_ff))) && (prop_sum < HW'(SLOTS));

   // Counter next values
   always_comb begin
      ptr_in    = ptr_ff;
      tvalid_in = 1'b0;
      run_in    = run_ff;
      k_in      = k_ff;
      if (cmd.load) begin
         ptr_in = '0;
         run_in = '0;
         k_in   = '0;
      end else begin
         if (cmd.clear || scan_issue) ptr_in = ptr_ff + PW'(1);
         tvalid_in = scan_issue;
         if (cmd.scan && tvalid_ff) run_in = slot_free ? run_inc[AMT_W-1:0] : '0;
         if (cmd.prop && prop_go) k_in = k_ff + KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         tvalid_ff <= 1'b0;
         run_ff    <= '0;
         k_ff      <= '0;
      end else begin
         ptr_ff    <= ptr_in;
         tvalid_ff <= tvalid_in;
         run_ff    <= run_in;
         k_ff      <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_issue) tag_ff <= ptr_ff[IDX_W-1:0];
      if (cmd.scan && hit) head_ff <= head_full[IDX_W-1:0];
   end

   // Write port selection
   always_comb begin
      ref_we    = 1'b0;
      ref_waddr = ptr_ff[IDX_W-1:0];
      ref_wdata = '0;
      if (cmd.clear) begin
         ref_we = 1'b1;
      end else if (cmd.prop && prop_go) begin
         ref_we    = 1'b1;
         ref_waddr = prop_sum[IDX_W-1:0];
         ref_wdata = value_ff;
      end
   end

   always_comb begin
      len_we    = 1'b0;
      len_waddr = ptr_ff[IDX_W-1:0];
      len_wdata = '0;
      if (cmd.clear) begin
         len_we = 1'b1;
      end else if (cmd.alloc_wr) begin
         len_we    = 1'b1;
         len_waddr = head_ff;
         len_wdata = amount_ff;
      end else if (cmd.len_clr) begin
         len_we    = 1'b1;
         len_waddr = idx_addr;
      end
   end

   // Count memory
   always_ff @(posedge clock) begin
      if (ref_we) ref_mem[ref_waddr] <= ref_wdata;
      if (scan_issue) ref_rd_ff <= ref_mem[ptr_ff[IDX_W-1:0]];
   end

   // Length memory
   always_ff @(posedge clock) begin
      if (len_we) len_mem[len_waddr] <= len_wdata;
      if (cmd.len_rd) len_rd_ff <= len_mem[idx_addr];
   end

   // Result assembly
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_status_ff <= ST_OK;
         res_base_ff   <= '0;
         res_len_ff    <= '0;
      end else begin
         if (cmd.fail) res_status_ff <= cmd.fail_code;
         if (cmd.scan && hit) res_base_ff <= head_full[BASE_W-1:0];
         if (cmd.len_cap) res_len_ff <= len_rd_ff;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_status_ff <= res_status_ff;
         rsp_base_ff   <= res_base_ff;
         rsp_len_ff    <= res_len_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_base_index  = rsp_base_ff;
   assign rsp_length_read = rsp_len_ff;

   // Status to the controller
   always_comb begin
      stat             = '0;
      stat.clr_last    = (ptr_ff == PW'(SLOTS - 1));
      stat.func        = func_ff;
      stat.amount_zero = (amount_ff == '0);
      stat.idx_ok      = (idx_hw < HW'(SLOTS));
      stat.hit         = hit;
      stat.scan_fail   = tvalid_ff && (tag_ff == IDX_W'(SLOTS - 1)) && !hit;
      stat.prop_done   = !prop_go;
      stat.value_zero  = (value_ff == '0);
      stat.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // Only one source drives the length write port at a time
   a_len_wr_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear, cmd.alloc_wr, cmd.len_clr}))
      else $error("length memory written from two sources");

   // A found run lies inside the heap
   a_hit_in_heap: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan && hit) |-> ((HW+1)'(head_full) + (HW+1)'(amount_ff) <= (HW+1)'(SLOTS)))
      else $error("allocated run extends past the heap");

   // A published result is offered in the next cycle
   a_publish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid_ff)
      else $error("published result not offered");

endmodule

`default_nettype wire

[rtl/first_fit_refcount_slot_allocator_core.sv]
`default_nettype none
// Channel   Dir  Handshake      Item fields
// req_ch    in   valid / ready  func, slot_index, run_amount, count_value
// rsp_ch    out  valid / ready  status, base_index, length_read
//
// After reset both slot memories are cleared, one entry per cycle, over all SLOTS
// entries; no item is accepted until that pass ends.
// In Allocate the first-fit search reads one count per cycle through the single
// read port of the count memory.
// Set-count writes one count per cycle along the run.
// One item is worked at a time; a finished result waits in the output register
// while the next item is accepted.

module first_fit_refcount_slot_allocator_core #(
   parameter int SLOTS      = 256,
   parameter int COUNT_BITS = 16
) (
   input wire logic      clock,
   input wire logic      reset,
   ffrsa_req_if.sink     req_ch,
   ffrsa_rsp_if.source   rsp_ch
);
   import ffrsa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencer
   ffrsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Heap memories, counters and result registers
   ffrsa_dp #(
      .SLOTS      (SLOTS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_func        (req_ch.func),
      .req_slot_index  (req_ch.slot_index),
      .req_run_amount  (req_ch.run_amount),
      .req_count_value (req_ch.count_value),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_status      (rsp_ch.status),
      .rsp_base_index  (rsp_ch.base_index),
      .rsp_length_read (rsp_ch.length_read)
   );

endmodule

`default_nettype wire
